FILE: design/irft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irft_pkg
// Types and constants shared by the IR remote frame transmitter.
// ----------------------------------------------------------------------------
package irft_pkg;

    // Input word: a tick or a send command with three frame nibbles
    typedef struct packed {
        logic       opcode;
        logic [3:0] nibble_a;
        logic [3:0] nibble_b;
        logic [3:0] nibble_c;
    } t_in_word;

    // Result word, one per input word
    typedef struct packed {
        logic ir_level;
        logic busy_res;
        logic accepted;
    } t_out_word;

    // Opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    // Config register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_HALF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES_MARK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_ONE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_ZERO     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_START    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RESEND_IVL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RESEND_EN    = 3'd6;

    // Config reset values
    localparam logic [7:0]  RST_CARRIER_HALF = 8'd10;
    localparam logic [3:0]  RST_PULSES_MARK  = 4'd6;
    localparam logic [10:0] RST_GAP_ONE      = 11'd685;
    localparam logic [10:0] RST_GAP_ZERO     = 11'd395;
    localparam logic [10:0] RST_GAP_START    = 11'd1158;
    localparam logic [23:0] RST_RESEND_IVL   = 24'd100000;
    localparam logic        RST_RESEND_EN    = 1'b1;

    localparam int unsigned RESEND_W = 24;

    // Frame layout: start symbol 0, data symbols 1..16, stop symbol 17
    localparam logic [4:0] LAST_SYMBOL = 5'd17;
    localparam logic [4:0] DATA_BITS   = 5'd16;
    localparam logic [3:0] CHECK_SEED  = 4'd15;

    // Transmit phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_MARK = 3'b010,
        PH_GAP  = 3'b100
    } t_phase;

endpackage

FILE: design/ir_remote_frame_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_remote_frame_transmitter
// Pulse-distance IR remote transmitter: one result word per input word.
// Result is registered: valid in the cycle after the input word is accepted.
// Throughput: 1 word per cycle while results are not stalled; all frame counters update in one pass.
// Reset (i_rst_n low, synchronous): config back to defaults, idle, no frame.
// ----------------------------------------------------------------------------
module ir_remote_frame_transmitter #(
    parameter int unsigned IDLE_TIMER_WIDTH = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input words
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  irft_pkg::t_in_word                    i_in_word,
    // result words
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output irft_pkg::t_out_word                   o_out_word,
    // config write port
    input  logic                                  i_cfg_we,
    input  logic [irft_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [irft_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import irft_pkg::*;

    // Compare width for idle timer vs. resend interval
    localparam int unsigned CMP_W =
        (IDLE_TIMER_WIDTH > RESEND_W) ? IDLE_TIMER_WIDTH : RESEND_W;

    // ---------------- config registers ----------------
    logic [7:0]          r_carrier_half;
    logic [3:0]          r_pulses_mark;
    logic [10:0]         r_gap_one;
    logic [10:0]         r_gap_zero;
    logic [10:0]         r_gap_start;
    logic [RESEND_W-1:0] r_resend_ivl;
    logic                r_resend_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_half <= RST_CARRIER_HALF;
            r_pulses_mark  <= RST_PULSES_MARK;
            r_gap_one      <= RST_GAP_ONE;
            r_gap_zero     <= RST_GAP_ZERO;
            r_gap_start    <= RST_GAP_START;
            r_resend_ivl   <= RST_RESEND_IVL;
            r_resend_en    <= RST_RESEND_EN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CARRIER_HALF: r_carrier_half <= i_cfg_data[7:0];
                CFG_PULSES_MARK:  r_pulses_mark  <= i_cfg_data[3:0];
                CFG_GAP_ONE:      r_gap_one      <= i_cfg_data[10:0];
                CFG_GAP_ZERO:     r_gap_zero     <= i_cfg_data[10:0];
                CFG_GAP_START:    r_gap_start    <= i_cfg_data[10:0];
                CFG_RESEND_IVL:   r_resend_ivl   <= i_cfg_data[RESEND_W-1:0];
                CFG_RESEND_EN:    r_resend_en    <= i_cfg_data[0];
                default:          ; // unused index: write ignored
            endcase
        end
    end

    // ---------------- frame state ----------------
    logic [15:0]                 r_frame_word, n_frame_word;
    logic                        r_frame_valid, n_frame_valid;
    t_phase                      r_phase, n_phase;
    logic [4:0]                  r_sym, n_sym;
    logic [3:0]                  r_pulse_cnt, n_pulse_cnt;
    logic [10:0]                 r_tick_cnt, n_tick_cnt;
    logic [IDLE_TIMER_WIDTH-1:0] r_idle_timer, n_idle_timer;

    // result register (output skid)
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out_word;

    logic in_acc;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // Automatic resend: idle, enabled, a frame exists, timer strictly past interval
    logic resend_start;
    assign resend_start = (r_phase == PH_IDLE) && r_resend_en && r_frame_valid &&
                          (CMP_W'(r_idle_timer) > CMP_W'(r_resend_ivl));

    // State seen by this tick: a resend restarts the frame at symbol 0, mark
    t_phase      cur_phase;
    logic [4:0]  cur_sym;
    logic [3:0]  cur_pulse;
    logic [10:0] cur_tick;
    assign cur_phase = resend_start ? PH_MARK : r_phase;
    assign cur_sym   = resend_start ? 5'd0    : r_sym;
    assign cur_pulse = resend_start ? 4'd0    : r_pulse_cnt;
    assign cur_tick  = resend_start ? 11'd0   : r_tick_cnt;

    // Zero half-period or zero pulse count act as 1
    logic [7:0] half_eff;
    logic [3:0] pulses_eff;
    assign half_eff   = (r_carrier_half == 8'd0) ? 8'd1 : r_carrier_half;
    assign pulses_eff = (r_pulses_mark == 4'd0)  ? 4'd1 : r_pulses_mark;

    // Gap length of the current symbol; data bits go MSB first
    logic        sym_is_data;
    logic [3:0]  bit_idx;
    logic [10:0] gap_len;
    assign sym_is_data = (cur_sym != 5'd0) && (cur_sym < LAST_SYMBOL);
    assign bit_idx     = 4'(DATA_BITS - cur_sym);
    assign gap_len     = !sym_is_data            ? r_gap_start :
                         r_frame_word[bit_idx]   ? r_gap_one   : r_gap_zero;

    // One tick of the frame sequencer
    logic        tk_level;
    t_phase      tk_phase;
    logic [4:0]  tk_sym;
    logic [3:0]  tk_pulse;
    logic [10:0] tk_tick;
    logic        tk_done;
    logic [11:0] tick_inc;
    logic [4:0]  pulse_inc;
    logic        sym_end;

    assign tick_inc  = {1'b0, cur_tick} + 12'd1;
    assign pulse_inc = {1'b0, cur_pulse} + 5'd1;

    always_comb begin
        tk_level = 1'b0;
        tk_phase = cur_phase;
        tk_sym   = cur_sym;
        tk_pulse = cur_pulse;
        tk_tick  = tick_inc[10:0];
        tk_done  = 1'b0;
        sym_end  = 1'b0;
        case (cur_phase)
            PH_MARK: begin
                tk_level = (cur_tick < {3'd0, half_eff});
                if (tick_inc >= {3'd0, half_eff, 1'b0}) begin
                    tk_tick  = 11'd0;
                    tk_pulse = pulse_inc[3:0];
                    if (pulse_inc >= {1'b0, pulses_eff}) begin
                        tk_pulse = 4'd0;
                        tk_phase = PH_GAP;
                        sym_end  = (gap_len == 11'd0);
                    end
                end
            end
            PH_GAP: begin
                sym_end = (tick_inc >= {1'b0, gap_len});
            end
            default: ;
        endcase
        // symbol finished: next symbol, or frame over after the stop symbol
        if (sym_end) begin
            tk_tick  = 11'd0;
            tk_pulse = 4'd0;
            if (cur_sym >= LAST_SYMBOL) begin
                tk_sym   = 5'd0;
                tk_phase = PH_IDLE;
                tk_done  = 1'b1;
            end else begin
                tk_sym   = cur_sym + 5'd1;
                tk_phase = PH_MARK;
            end
        end
    end

    // Check nibble for a new frame
    logic [3:0] check_nib;
    assign check_nib = CHECK_SEED ^ i_in_word.nibble_a ^ i_in_word.nibble_b ^
                       i_in_word.nibble_c;

    // Next state and result for the accepted word
    always_comb begin
        n_frame_word  = r_frame_word;
        n_frame_valid = r_frame_valid;
        n_phase       = r_phase;
        n_sym         = r_sym;
        n_pulse_cnt   = r_pulse_cnt;
        n_tick_cnt    = r_tick_cnt;
        n_idle_timer  = r_idle_timer;
        n_out_word    = '0;
        if (in_acc) begin
            if (i_in_word.opcode == OP_SEND) begin
                n_out_word.busy_res = 1'b1;
                // send while busy is dropped
                if (r_phase == PH_IDLE) begin
                    n_frame_word  = {i_in_word.nibble_a, i_in_word.nibble_b,
                                     i_in_word.nibble_c, check_nib};
                    n_frame_valid = 1'b1;
                    n_phase       = PH_MARK;
                    n_sym         = 5'd0;
                    n_pulse_cnt   = 4'd0;
                    n_tick_cnt    = 11'd0;
                    n_out_word.accepted = 1'b1;
                end
            end else if (cur_phase != PH_IDLE) begin
                n_out_word.busy_res = 1'b1;
                n_out_word.ir_level = tk_level;
                n_phase     = tk_phase;
                n_sym       = tk_sym;
                n_pulse_cnt = tk_pulse;
                n_tick_cnt  = tk_tick;
                if (tk_done) begin
                    n_idle_timer = '0;
                end
            end else if (r_idle_timer != '1) begin
                // idle: count up, saturating
                n_idle_timer = r_idle_timer + IDLE_TIMER_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_word  <= '0;
            r_frame_valid <= 1'b0;
            r_phase       <= PH_IDLE;
            r_sym         <= '0;
            r_pulse_cnt   <= '0;
            r_tick_cnt    <= '0;
            r_idle_timer  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_frame_word  <= n_frame_word;
            r_frame_valid <= n_frame_valid;
            r_phase       <= n_phase;
            r_sym         <= n_sym;
            r_pulse_cnt   <= n_pulse_cnt;
            r_tick_cnt    <= n_tick_cnt;
            r_idle_timer  <= n_idle_timer;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: loaded on accept, held while stalled
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTH
    // a taken send always reports the frame in progress
    a_accepted_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.accepted) |-> o_out_word.busy_res)
        else $error("accepted result without busy");

    // emitter only lights inside a frame
    a_level_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.ir_level) |-> o_out_word.busy_res)
        else $error("ir_level high outside a frame");

    // idle sequencer rests at symbol 0 with cleared counters
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_sym == 5'd0 && r_pulse_cnt == 4'd0 &&
                                  r_tick_cnt == 11'd0))
        else $error("idle with live symbol state");

    // a send taken while idle starts a frame
    a_send_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.opcode == OP_SEND && r_phase == PH_IDLE)
            |=> (r_phase == PH_MARK && r_frame_valid))
        else $error("send did not start a frame");

    // symbol index never passes the stop symbol
    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sym <= LAST_SYMBOL)
        else $error("symbol index out of range");
`endif

endmodule
